@@ src/gioc_pkg.sv @@
// gioc_pkg: types, sizes and state codes for the grouped index of coincidence block
// used by gioc_ram users, gioc_div and grouped_index_of_coincidence
// no dependencies
`timescale 1ns / 1ps

package gioc_pkg;

   localparam int MAX_TEXT = 1024;
   localparam int GROUPS   = 10;
   localparam int LETTERS  = 26;
   localparam int IC_SCALE = 100000;

   localparam int LETTER_W = 5;
   localparam int DIGIT_W  = 4;
   localparam int AVG_W    = 17;
   localparam int GCNT_W   = 4;

   localparam int CNT_W     = $clog2(MAX_TEXT + 1);
   localparam int DEPTH     = GROUPS * LETTERS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int LET_IDX_W = $clog2(LETTERS);
   localparam int GRP_IDX_W = $clog2(GROUPS);
   localparam int SCALE_W   = $clog2(IC_SCALE + 1);
   localparam int IC_W      = SCALE_W;
   localparam int PAIR_W    = $clog2(MAX_TEXT * (MAX_TEXT - 1) + 1);
   localparam int NUM_W     = PAIR_W + SCALE_W;
   localparam int SUM_W     = $clog2(GROUPS * IC_SCALE + 1);
   localparam int GSUM_W    = $clog2(GROUPS + 1);
   localparam int DIV_W     = NUM_W;
   localparam int DVS_W     = (CNT_W > GSUM_W) ? CNT_W : GSUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   typedef struct packed {
      logic [LETTER_W-1:0] letter;
      logic [DIGIT_W-1:0]  digit;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [AVG_W-1:0]  average_ic;
      logic [GCNT_W-1:0] groups_counted;
      logic              no_groups;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INC,
      ST_SCAN,
      ST_SCAN_END,
      ST_CHECK,
      ST_MUL,
      ST_DIVA_GO,
      ST_DIVA_WAIT,
      ST_DIVB_GO,
      ST_DIVB_WAIT,
      ST_NEXT,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_FINISH
   } state_type;

   // flat count-store address of one letter of one group
   function automatic logic [ADDR_W-1:0] entry_addr(input logic [LETTER_W-1:0] letter,
                                                    input logic [DIGIT_W-1:0] digit);
      int a;
      a = int'(digit) * LETTERS + int'(letter);
      return ADDR_W'(a);
   endfunction

endpackage

@@ src/gioc_ram.sv @@
// gioc_ram: generic simple dual-port ram, one write and one registered read port
// no package dependencies
`timescale 1ns / 1ps

module gioc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/gioc_div.sv @@
// gioc_div: restoring divider, one quotient bit per cycle
// depends on gioc_pkg
`timescale 1ns / 1ps

module gioc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  gioc_pkg::div_req_type div_req,
   output gioc_pkg::div_rsp_type div_rsp
);

   import gioc_pkg::*;

   logic [DIV_W-1:0]     work_ff, work_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DVS_W:0] shifted;
   logic [DVS_W:0] diff;
   logic           ge;

   assign shifted = {rem_ff, work_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = shifted >= {1'b0, dvs_ff};

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         work_in = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // dividend shifts out at the top while quotient bits fill in below
         work_in = {work_ff[DIV_W-2:0], ge};
         rem_in  = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = work_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !$past(div_req.start) |-> rem_ff < dvs_ff || dvs_ff == '0)
      else $error("divider remainder not below divisor");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for more than one cycle");

endmodule

@@ src/grouped_index_of_coincidence.sv @@
// grouped_index_of_coincidence: top level, letter counting and per-text ic sequencer
// depends on gioc_pkg, gioc_ram, gioc_div
//
//   channel  ports                          direction  holds
//   request  req_valid req_ready req_data   in         letter, digit, last
//   response rsp_valid rsp_ready rsp_data   out        average_ic, groups_counted, no_groups
//
// each request reads the count store, then increments the tally and writes it back if the letter counts.
// a request with last adds the compute walk: a scan of each group's tallies in the count
// store, a multiply and two divisions per group with over one letter, and one division for
// the mean if any group counted, all divisions on the single shared one-bit-per-cycle divider.
// after reset the count store is swept to zero over all DEPTH (260) entries, req_ready low.
// the result waits in an output register, so a stalled response holds up only the
// end of the next text.
`timescale 1ns / 1ps

module grouped_index_of_coincidence (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gioc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gioc_pkg::rsp_type rsp_data
);

   import gioc_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]     text_len_ff, text_len_in;
   logic                 inc_en_ff, inc_en_in;
   logic [ADDR_W-1:0]    inc_addr_ff, inc_addr_in;
   logic                 last_ff, last_in;
   logic [ADDR_W-1:0]    scan_addr_ff, scan_addr_in;
   logic [LET_IDX_W-1:0] let_ff, let_in;
   logic [GRP_IDX_W-1:0] grp_ff, grp_in;
   logic                 acc_vld_ff, acc_vld_in;
   logic [CNT_W-1:0]     len_ff, len_in;
   logic [PAIR_W-1:0]    pairs_ff, pairs_in;
   logic [DIV_W-1:0]     num_ff, num_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [GSUM_W-1:0]    groups_ff, groups_in;
   logic [AVG_W-1:0]     avg_ff, avg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [CNT_W-1:0]  ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [CNT_W-1:0]  ram_rd_data;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic                 accept;
   logic                 count_ok;
   logic                 rsp_free;
   logic [CNT_W-1:0]     t_dec;
   logic [2*CNT_W-1:0]   sq;
   logic [NUM_W-1:0]     num_prod;
   localparam logic [SCALE_W-1:0] SCALE_C = SCALE_W'(IC_SCALE);

   gioc_ram #(
      .WIDTH (CNT_W),
      .DEPTH (DEPTH)
   ) u_counts (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   gioc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept   = req_valid && req_ready;
   assign count_ok = (int'(req_data.letter) < LETTERS) && (int'(req_data.digit) < GROUPS)
                     && (int'(text_len_ff) < MAX_TEXT);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // tally t contributes t*(t-1); t = 0 gives 0 despite the wrap of t-1
   assign t_dec    = ram_rd_data - CNT_W'(1);
   assign sq       = (2*CNT_W)'(ram_rd_data) * (2*CNT_W)'(t_dec);
   assign num_prod = {{SCALE_W{1'b0}}, pairs_ff} * {{PAIR_W{1'b0}}, SCALE_C};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (scan_addr_ff == ADDR_W'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_INC;
         end
         ST_INC: begin
            state_in = last_ff ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (let_ff == LET_IDX_W'(LETTERS - 1)) state_in = ST_SCAN_END;
         end
         ST_SCAN_END: state_in = ST_CHECK;
         ST_CHECK: begin
            state_in = (len_ff > CNT_W'(1)) ? ST_MUL : ST_NEXT;
         end
         ST_MUL:     state_in = ST_DIVA_GO;
         ST_DIVA_GO: state_in = ST_DIVA_WAIT;
         ST_DIVA_WAIT: begin
            if (div_rsp.done) state_in = ST_DIVB_GO;
         end
         ST_DIVB_GO: state_in = ST_DIVB_WAIT;
         ST_DIVB_WAIT: begin
            if (div_rsp.done) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (grp_ff == GRP_IDX_W'(GROUPS - 1)) begin
               state_in = (groups_ff == '0) ? ST_FINISH : ST_AVG_GO;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_AVG_GO: state_in = ST_AVG_WAIT;
         ST_AVG_WAIT: begin
            if (div_rsp.done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs: handshake, count store and divider control
   always_comb begin
      req_ready        = 1'b0;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = scan_addr_ff;
      ram_wr_data      = '0;
      ram_rd_addr      = scan_addr_ff;
      div_req.start    = 1'b0;
      div_req.dividend = num_ff;
      div_req.divisor  = DVS_W'(len_ff);
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            ram_rd_addr = entry_addr(req_data.letter, req_data.digit);
         end
         ST_INC: begin
            ram_wr_en   = inc_en_ff;
            ram_wr_addr = inc_addr_ff;
            ram_wr_data = ram_rd_data + CNT_W'(1);
         end
         ST_SCAN: begin
            // read each tally and clear it for the next text
            ram_wr_en = 1'b1;
         end
         ST_DIVA_GO: begin
            div_req.start = 1'b1;
         end
         ST_DIVB_GO: begin
            div_req.start   = 1'b1;
            div_req.divisor = DVS_W'(len_ff - CNT_W'(1));
         end
         ST_AVG_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(sum_ff);
            div_req.divisor  = DVS_W'(groups_ff);
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      text_len_in  = text_len_ff;
      inc_en_in    = inc_en_ff;
      inc_addr_in  = inc_addr_ff;
      last_in      = last_ff;
      scan_addr_in = scan_addr_ff;
      let_in       = let_ff;
      grp_in       = grp_ff;
      acc_vld_in   = acc_vld_ff;
      len_in       = len_ff;
      pairs_in     = pairs_ff;
      num_in       = num_ff;
      sum_in       = sum_ff;
      groups_in    = groups_ff;
      avg_in       = avg_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if ((state_ff == ST_SCAN || state_ff == ST_SCAN_END) && acc_vld_ff) begin
         len_in   = len_ff + ram_rd_data;
         pairs_in = pairs_ff + PAIR_W'(sq);
      end

      case (state_ff)
         ST_CLEAR: begin
            scan_addr_in = scan_addr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               inc_en_in   = count_ok;
               inc_addr_in = entry_addr(req_data.letter, req_data.digit);
               last_in     = req_data.last;
               if (count_ok) text_len_in = text_len_ff + CNT_W'(1);
            end
         end
         ST_INC: begin
            if (last_ff) begin
               text_len_in  = '0;
               scan_addr_in = '0;
               let_in       = '0;
               grp_in       = '0;
               acc_vld_in   = 1'b0;
               len_in       = '0;
               pairs_in     = '0;
               sum_in       = '0;
               groups_in    = '0;
            end
         end
         ST_SCAN: begin
            scan_addr_in = scan_addr_ff + ADDR_W'(1);
            let_in       = let_ff + LET_IDX_W'(1);
            acc_vld_in   = 1'b1;
         end
         ST_SCAN_END: begin
            acc_vld_in = 1'b0;
         end
         ST_MUL: begin
            num_in = num_prod;
         end
         ST_DIVA_WAIT: begin
            if (div_rsp.done) num_in = div_rsp.quotient;
         end
         ST_DIVB_WAIT: begin
            if (div_rsp.done) begin
               sum_in    = sum_ff + SUM_W'(div_rsp.quotient[IC_W-1:0]);
               groups_in = groups_ff + GSUM_W'(1);
            end
         end
         ST_NEXT: begin
            if (grp_ff != GRP_IDX_W'(GROUPS - 1)) begin
               grp_in   = grp_ff + GRP_IDX_W'(1);
               let_in   = '0;
               len_in   = '0;
               pairs_in = '0;
            end
         end
         ST_AVG_WAIT: begin
            if (div_rsp.done) avg_in = AVG_W'(div_rsp.quotient);
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.no_groups      = (groups_ff == '0);
               rsp_data_in.average_ic     = (groups_ff == '0) ? '0 : avg_ff;
               rsp_data_in.groups_counted = GCNT_W'(groups_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         text_len_ff  <= '0;
         scan_addr_ff <= '0;
         acc_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         text_len_ff  <= text_len_in;
         scan_addr_ff <= scan_addr_in;
         acc_vld_ff   <= acc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      inc_en_ff   <= inc_en_in;
      inc_addr_ff <= inc_addr_in;
      last_ff     <= last_in;
      let_ff      <= let_in;
      grp_ff      <= grp_in;
      len_ff      <= len_in;
      pairs_ff    <= pairs_in;
      num_ff      <= num_in;
      sum_ff      <= sum_in;
      groups_ff   <= groups_in;
      avg_ff      <= avg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_last_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last |=> ##1 !req_ready)
      else $error("request taken during the compute walk");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_text_len_bound: assert property (@(posedge clock) disable iff (reset)
      int'(text_len_ff) <= MAX_TEXT)
      else $error("text length beyond limit");

   a_no_groups_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_groups |->
         rsp_data.average_ic == '0 && rsp_data.groups_counted == '0)
      else $error("empty result with nonzero fields");

   a_avg_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.no_groups |-> int'(rsp_data.average_ic) <= IC_SCALE)
      else $error("average index above scale");

endmodule

@@ tb/grouped_index_of_coincidence_tb.sv @@
// grouped_index_of_coincidence_tb: self-checking bench for the grouped index of coincidence
// block, with directed and random texts, random idling on both channels and a tally model
// depends on gioc_pkg and grouped_index_of_coincidence
`timescale 1ns / 1ps

module grouped_index_of_coincidence_tb;
   import gioc_pkg::*;

   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int SETTLE_CYCLES   = 1500;
   localparam int RSP_HOLD_CYCLES = 3000;
   localparam int RANDOM_ITEMS    = 150;

   // text shapes for the random part
   typedef enum int {
      TEXT_PLAIN,
      TEXT_SKEWED,
      TEXT_NOISY
   } text_shape_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // tally model of the block
   int unsigned letter_tally[GROUPS][LETTERS];
   int unsigned group_len[GROUPS];
   int unsigned text_len;
   rsp_type     expected_ic_q[$];

   int  error_count = 0;
   int  results_checked = 0;
   int  texts_sent = 0;
   int  letters_sent = 0;
   int  random_items = 0;
   int  idle_cycles = 0;
   int  rsp_stall_left = 0;
   int  rsp_hold_left = 0;
   bit  gaps_on = 1'b1;
   bit  hold_request = 1'b0;

   grouped_index_of_coincidence i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic void clear_tallies();
      for (int g = 0; g < GROUPS; g++) begin
         group_len[g] = 0;
         for (int k = 0; k < LETTERS; k++) letter_tally[g][k] = 0;
      end
      text_len = 0;
   endfunction

   // mean scaled ic over groups holding more than one letter
   function automatic rsp_type text_ic_result();
      longint unsigned sum;
      longint unsigned pairs;
      longint unsigned len;
      longint unsigned t;
      int              n;
      rsp_type         r;
      sum = 0;
      n = 0;
      for (int g = 0; g < GROUPS; g++) begin
         if (group_len[g] > 1) begin
            len = group_len[g];
            pairs = 0;
            for (int k = 0; k < LETTERS; k++) begin
               t = letter_tally[g][k];
               if (t > 0) pairs += t * (t - 1);
            end
            sum += (pairs * IC_SCALE / len) / (len - 1);
            n++;
         end
      end
      r = '0;
      if (n == 0) begin
         r.no_groups = 1'b1;
      end else begin
         r.average_ic = AVG_W'(sum / n);
         r.groups_counted = GCNT_W'(n);
      end
      return r;
   endfunction

   function automatic void tally_request(req_type r);
      if (r.letter < LETTERS && r.digit < GROUPS && text_len < MAX_TEXT) begin
         letter_tally[r.digit][r.letter]++;
         group_len[r.digit]++;
         text_len++;
      end
      if (r.last) begin
         expected_ic_q.push_back(text_ic_result());
         clear_tallies();
      end
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 20);
      return $urandom_range(50, 300);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic check_ic_result(rsp_type got);
      rsp_type want;
      if (expected_ic_q.size() == 0) begin
         report_mismatch("unexpected response, average_ic", got.average_ic, -1);
         return;
      end
      want = expected_ic_q.pop_front();
      results_checked++;
      if (got.average_ic !== want.average_ic)
         report_mismatch("average_ic", got.average_ic, want.average_ic);
      if (got.groups_counted !== want.groups_counted)
         report_mismatch("groups_counted", got.groups_counted, want.groups_counted);
      if (got.no_groups !== want.no_groups)
         report_mismatch("no_groups", got.no_groups, want.no_groups);
   endtask

   // response side: checking, random stalls and the requested long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_ic_result(rsp_data);
         if (hold_request) begin
            rsp_hold_left = RSP_HOLD_CYCLES;
            hold_request <= 1'b0;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) rsp_stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", idle_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // valid stays high between back-to-back requests
   task automatic send_letter(input logic [LETTER_W-1:0] letter,
                              input logic [DIGIT_W-1:0] digit, input logic last);
      int      gap;
      req_type r;
      r.letter = letter;
      r.digit = digit;
      r.last = last;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      tally_request(r);
      letters_sent++;
      random_items++;
      if (last) texts_sent++;
   endtask

   // drop valid, then wait until every expected response has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_ic_q.size() != 0) @(posedge clock);
   endtask

   task automatic send_text(int len, text_shape_type shape);
      logic [LETTER_W-1:0] letter;
      logic [DIGIT_W-1:0]  digit;
      int                  alpha;
      int                  ngroups;
      alpha = $urandom_range(1, 4);
      ngroups = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
         case (shape)
            TEXT_SKEWED: begin
               letter = LETTER_W'($urandom_range(0, alpha - 1));
               digit = DIGIT_W'($urandom_range(0, ngroups - 1));
            end
            TEXT_NOISY: begin
               letter = LETTER_W'($urandom_range(0, 31));
               digit = DIGIT_W'($urandom_range(0, 15));
            end
            default: begin
               letter = LETTER_W'($urandom_range(0, LETTERS - 1));
               digit = DIGIT_W'($urandom_range(0, GROUPS - 1));
            end
         endcase
         send_letter(letter, digit, i == len - 1);
      end
   endtask

   task automatic test_directed();
      // single letter: no group qualifies
      send_letter(0, 0, 1'b1);
      // only an ignored letter and digit, nothing counted
      send_letter(31, 15, 1'b1);
      // two equal letters in the top group give the full scale
      send_letter(25, 9, 1'b0);
      send_letter(25, 9, 1'b1);
      // distinct letters, with out-of-range letter and digits dropped
      send_letter(0, 0, 1'b0);
      send_letter(1, 0, 1'b0);
      send_letter(26, 0, 1'b0);
      send_letter(3, 10, 1'b0);
      send_letter(3, 15, 1'b0);
      send_letter(2, 0, 1'b1);
      // last letter itself out of range still closes the text
      send_letter(7, 4, 1'b0);
      send_letter(7, 4, 1'b0);
      send_letter(7, 5, 1'b0);
      send_letter(8, 5, 1'b0);
      send_letter(30, 4, 1'b1);
      // every group holding a pair of equal letters
      for (int g = 0; g < GROUPS; g++) begin
         send_letter(LETTER_W'(g), DIGIT_W'(g), 1'b0);
         send_letter(LETTER_W'(g), DIGIT_W'(g), g == GROUPS - 1);
      end
      wait_for_results();
   endtask

   task automatic test_text_overflow();
      gaps_on = 1'b0;
      // letters past the text limit are dropped
      send_text(MAX_TEXT + 8, TEXT_PLAIN);
      gaps_on = 1'b1;
      wait_for_results();
   endtask

   task automatic test_backpressure();
      wait_for_results();
      hold_request <= 1'b1;
      gaps_on = 1'b0;
      for (int i = 0; i < 6; i++) send_text($urandom_range(2, 5), TEXT_SKEWED);
      gaps_on = 1'b1;
      // sender pauses until the block has drained
      wait_for_results();
   endtask

   task automatic test_random_texts();
      int             pick;
      text_shape_type shape;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) shape = TEXT_PLAIN;
         else if (pick < 85) shape = TEXT_SKEWED;
         else shape = TEXT_NOISY;
         // stretches with no idling now and then
         gaps_on = ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 9);
         if (pick == 0) send_text($urandom_range(1, 2), shape);
         else if (pick < 8) send_text($urandom_range(3, 30), shape);
         else send_text($urandom_range(31, 90), shape);
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      clear_tallies();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_text_overflow();
      test_random_texts();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("ran %0d texts in %0d letter requests, %0d results checked,", texts_sent,
               letters_sent, results_checked);
      $display("including empty, overflowing, noisy and stalled texts; %0d mismatches",
               error_count + expected_ic_q.size());
      if (error_count == 0 && expected_ic_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/gioc_pkg.sv
src/gioc_ram.sv
src/gioc_div.sv
src/grouped_index_of_coincidence.sv
tb/grouped_index_of_coincidence_tb.sv
